// ----- hw/rtl/page_framebuffer_text_renderer_defines.svh -----
// Assertion macros for the page framebuffer text renderer
`ifndef PAGE_FRAMEBUFFER_TEXT_RENDERER_DEFINES_SVH
`define PAGE_FRAMEBUFFER_TEXT_RENDERER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PFTR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFTR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFTR_ASSERT(label, clk, rst_n, prop, msg)
`define PFTR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/pftr_pkg.sv -----
package pftr_pkg;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_CHAR  = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       pixel_on;
        logic [7:0] char_code;
        logic [2:0] page_sel;
        logic [2:0] segment_sel;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       last;
    } t_out_item;

    // Font column lookup; unknown codes and the spacing column are blank
    function automatic logic [7:0] glyph_column(input logic [7:0] code,
                                                input logic [2:0] col);
        logic [39:0] g;
        logic [7:0]  res;
        g = 40'h0;
        case (code)
            "0": g = 40'h3E_51_49_45_3E; "1": g = 40'h00_42_7F_40_00;
            "2": g = 40'h42_61_51_49_46; "3": g = 40'h21_41_45_4B_31;
            "4": g = 40'h18_14_12_7F_10; "5": g = 40'h27_45_45_45_39;
            "6": g = 40'h3C_4A_49_49_30; "7": g = 40'h01_71_09_05_03;
            "8": g = 40'h36_49_49_49_36; "9": g = 40'h06_49_49_29_1E;
            "A": g = 40'h7E_11_11_11_7E; "B": g = 40'h7F_49_49_49_36;
            "C": g = 40'h3E_41_41_41_22; "D": g = 40'h7F_41_41_22_1C;
            "E": g = 40'h7F_49_49_49_41; "F": g = 40'h7F_09_09_09_01;
            "G": g = 40'h3E_41_49_49_7A; "H": g = 40'h7F_08_08_08_7F;
            "I": g = 40'h00_41_7F_41_00; "J": g = 40'h20_40_41_3F_01;
            "K": g = 40'h7F_08_14_22_41; "L": g = 40'h7F_40_40_40_40;
            "M": g = 40'h7F_02_0C_02_7F; "N": g = 40'h7F_04_08_10_7F;
            "O": g = 40'h3E_41_41_41_3E; "P": g = 40'h7F_09_09_09_06;
            "Q": g = 40'h3E_41_51_21_5E; "R": g = 40'h7F_09_19_29_46;
            "S": g = 40'h46_49_49_49_31; "T": g = 40'h01_01_7F_01_01;
            "U": g = 40'h3F_40_40_40_3F; "V": g = 40'h1F_20_40_20_1F;
            "W": g = 40'h3F_40_38_40_3F; "X": g = 40'h63_14_08_14_63;
            "Y": g = 40'h07_08_70_08_07; "Z": g = 40'h61_51_49_45_43;
            "a": g = 40'h20_54_54_54_78; "b": g = 40'h7F_48_44_44_38;
            "c": g = 40'h38_44_44_44_20; "d": g = 40'h38_44_44_48_7F;
            "e": g = 40'h38_54_54_54_18; "f": g = 40'h08_7E_09_01_02;
            "g": g = 40'h0C_52_52_52_3E; "h": g = 40'h7F_08_04_04_78;
            "i": g = 40'h00_44_7D_40_00; "j": g = 40'h20_40_44_3D_00;
            "k": g = 40'h7F_10_28_44_00; "l": g = 40'h00_41_7F_40_00;
            "m": g = 40'h7C_04_18_04_78; "n": g = 40'h7C_08_04_04_78;
            "o": g = 40'h38_44_44_44_38; "p": g = 40'h7C_14_14_14_08;
            "q": g = 40'h08_14_14_18_7C; "r": g = 40'h7C_08_04_04_08;
            "s": g = 40'h48_54_54_54_20; "t": g = 40'h04_3F_44_40_20;
            "u": g = 40'h3C_40_40_20_7C; "v": g = 40'h1C_20_40_20_1C;
            "w": g = 40'h3C_40_30_40_3C; "x": g = 40'h44_28_10_28_44;
            "y": g = 40'h0C_50_50_50_3C; "z": g = 40'h44_64_54_4C_44;
            ":": g = 40'h00_36_36_00_00; ".": g = 40'h00_60_60_00_00;
            "-": g = 40'h08_08_08_08_08; "%": g = 40'h63_13_08_64_63;
            "/": g = 40'h20_10_08_04_02;
            default: g = 40'h0;
        endcase
        case (col)
            3'd0:    res = g[39:32];
            3'd1:    res = g[31:24];
            3'd2:    res = g[23:16];
            3'd3:    res = g[15:8];
            3'd4:    res = g[7:0];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

// ----- hw/rtl/page_framebuffer_text_renderer.sv -----
// Channel  | Handshake             | Payload
// input    | i_valid / o_stall     | i_item  (t_in_item)
// output   | o_valid / i_stall     | o_item  (t_out_item)
// Setting a pixel takes the request, then makes one read-modify-write pass; a character takes
// the request, then makes two read-modify-write passes per column over six columns on the store.
// A flush takes the request, emits the command bytes (segment 0 only), then reads and emits each data byte.
// After reset and on clear, the store is wiped one byte a cycle
// (SCREEN_WIDTH*SCREEN_PAGES bytes, 1024 by default); no request is taken then.
// A two-entry queue keeps accepting requests while the output is stalled, until it is full.
`include "page_framebuffer_text_renderer_defines.svh"
module page_framebuffer_text_renderer #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_PAGES  = 8,
    parameter int SEGMENT_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pftr_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output pftr_pkg::t_out_item o_item
);
    import pftr_pkg::*;

    logic     q_full, push, pop, q_valid, clearing, front_stall;
    t_in_item push_item, q_item;

    pftr_front #(
        .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_PAGES(SCREEN_PAGES),
        .SEGMENT_BYTES(SEGMENT_BYTES)
    ) u_front (
        .i_valid(i_valid), .o_stall(front_stall), .i_item(i_item),
        .i_q_full(q_full || clearing), .o_push(push), .o_item(push_item)
    );

    pftr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(push_item),
        .o_full(q_full), .i_pop(pop), .o_valid(q_valid), .o_data(q_item)
    );

    pftr_back #(
        .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_PAGES(SCREEN_PAGES),
        .SEGMENT_BYTES(SEGMENT_BYTES)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_item(q_item),
        .o_pop(pop), .o_clearing(clearing), .o_valid(o_valid), .i_stall(i_stall),
        .o_item(o_item)
    );

    assign o_stall = front_stall;

    `PFTR_ASSERT(a_no_push_full, i_clk, i_rst_n, q_full |-> !push, "push into full queue")
    `PFTR_ASSERT(a_no_pop_empty, i_clk, i_rst_n, pop |-> q_valid, "pop from empty queue")
    `PFTR_ASSERT(a_clear_blocks, i_clk, i_rst_n, clearing |-> !push, "request taken while clearing")
endmodule

// ----- hw/rtl/pftr_queue.sv -----
module pftr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pftr_pkg::t_in_item i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output pftr_pkg::t_in_item o_data
);
    import pftr_pkg::*;

    t_in_item   r_slot [2];
    logic       r_wptr, r_rptr, n_wptr, n_rptr;
    logic [1:0] r_count, n_count;

    // Two-entry request queue between front and back
    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rptr];
endmodule

// ----- hw/rtl/pftr_front.sv -----
module pftr_front #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_PAGES  = 8,
    parameter int SEGMENT_BYTES = 16
) (
    input  logic               i_valid,
    output logic               o_stall,
    input  pftr_pkg::t_in_item i_item,
    input  logic               i_q_full,
    output logic               o_push,
    output pftr_pkg::t_in_item o_item
);
    import pftr_pkg::*;

    localparam int ROWS = SCREEN_PAGES * 8;

    logic [11:0] seg_start;
    logic        drop;

    // Drop requests that change nothing and emit nothing
    always_comb begin
        seg_start = 12'(i_item.segment_sel) * 12'(SEGMENT_BYTES);
        drop = 1'b0;
        unique case (i_item.mode)
            MODE_CLEAR: drop = 1'b0;
            MODE_PIXEL, MODE_CHAR:
                drop = (32'(i_item.pos_x) >= SCREEN_WIDTH) || (32'(i_item.pos_y) >= ROWS);
            MODE_FLUSH:
                drop = (32'(i_item.page_sel) >= SCREEN_PAGES)
                    || (32'(seg_start) >= SCREEN_WIDTH);
            default: drop = 1'b1;
        endcase
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && !drop;
    assign o_item  = i_item;
endmodule

// ----- hw/rtl/pftr_back.sv -----
module pftr_back #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_PAGES  = 8,
    parameter int SEGMENT_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  pftr_pkg::t_in_item  i_q_item,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_valid,
    input  logic                i_stall,
    output pftr_pkg::t_out_item o_item
);
    import pftr_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = SCREEN_PAGES * 8;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_WR    = 3'd3;
    localparam logic [2:0] ST_CMD   = 3'd4;
    localparam logic [2:0] ST_FRD   = 3'd5;
    localparam logic [2:0] ST_FOUT  = 3'd6;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [2:0]    r_state, n_state;
    logic [AW:0]   r_addr, n_addr;
    t_in_item      r_cur;
    logic [3:0]    r_pass, n_pass;
    logic [2:0]    r_col, n_col;
    logic [5:0]    r_cnt, n_cnt;
    logic [1:0]    r_cmd, n_cmd;
    logic          r_ovalid, n_ovalid;
    t_out_item     r_out, n_out;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;
    logic [8:0]    cx;
    logic [8:0]    ry;
    logic [7:0]    gcol;
    logic [7:0]    mask, bits;
    logic [15:0]   sh_mask, sh_bits;
    logic          col_ok, pass_ok;
    logic [11:0]   seg_start;
    logic [12:0]   col_end;
    logic          out_free;

    // Current glyph column and the row band for this pass
    always_comb begin
        cx        = 9'(r_cur.pos_x) + 9'(r_col);
        ry        = {1'b0, r_cur.pos_y[7:3], 3'b000} + (r_pass[0] ? 9'd8 : 9'd0);
        gcol      = glyph_column(r_cur.char_code, r_col);
        // rows of the glyph shifted by y within this page pair
        sh_mask   = 16'h007F << r_cur.pos_y[2:0];
        sh_bits   = {8'h00, gcol & 8'h7F} << r_cur.pos_y[2:0];
        mask      = r_pass[0] ? sh_mask[15:8] : sh_mask[7:0];
        bits      = r_pass[0] ? sh_bits[15:8] : sh_bits[7:0];
        col_ok    = (32'(cx) < SCREEN_WIDTH);
        pass_ok   = (32'(ry) < ROWS) && (mask != 8'h00);
        seg_start = 12'(r_cur.segment_sel) * 12'(SEGMENT_BYTES);
        col_end   = 13'(seg_start) + 13'(r_cnt);
        out_free  = !r_ovalid || !i_stall;
    end

    // Sequence clear, pixel, glyph and flush work
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_pass    = r_pass;
        n_col     = r_col;
        n_cnt     = r_cnt;
        n_cmd     = r_cmd;
        n_ovalid  = r_ovalid && i_stall;
        n_out     = r_out;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_addr[AW-1:0];
        mem_wdata = 8'h00;
        mem_raddr = r_addr[AW-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (32'(r_addr) == DEPTH - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_pass = 4'd0;
                    n_col  = 3'd0;
                    n_cnt  = 6'd0;
                    n_cmd  = 2'd0;
                    n_addr = '0;
                    unique case (i_q_item.mode)
                        MODE_CLEAR: n_state = ST_CLEAR;
                        MODE_PIXEL, MODE_CHAR: n_state = ST_RD;
                        MODE_FLUSH: n_state = (i_q_item.segment_sel == 3'd0) ? ST_CMD : ST_FRD;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD: begin
                // Address of the byte to update
                if (r_cur.mode == MODE_PIXEL) begin
                    n_addr = (AW + 1)'(32'(r_cur.pos_y[7:3]) * SCREEN_WIDTH
                        + 32'(r_cur.pos_x));
                end else begin
                    n_addr = (AW + 1)'(32'(ry[8:3]) * SCREEN_WIDTH + 32'(cx));
                end
                mem_raddr = n_addr[AW-1:0];
                n_state   = ST_WR;
            end
            ST_WR: begin
                if (r_cur.mode == MODE_PIXEL) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_cur.pixel_on
                        ? (r_rdata | (8'h01 << r_cur.pos_y[2:0]))
                        : (r_rdata & ~(8'h01 << r_cur.pos_y[2:0]));
                    n_state   = ST_IDLE;
                end else begin
                    mem_we    = col_ok && pass_ok;
                    mem_wdata = (r_rdata & ~mask) | bits;
                    if (r_pass[0]) begin
                        n_pass = 4'd0;
                        if (r_col == 3'(GLYPH_COLS)) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_col   = r_col + 3'd1;
                            n_state = ST_RD;
                        end
                    end else begin
                        n_pass  = 4'd1;
                        n_state = ST_RD;
                    end
                end
            end
            ST_CMD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out.is_command = 1'b1;
                    n_out.last = 1'b0;
                    case (r_cmd)
                        2'd0:    n_out.out_byte = CMD_PAGE_BASE | 8'(r_cur.page_sel);
                        2'd1:    n_out.out_byte = CMD_COL_LOW;
                        default: n_out.out_byte = CMD_COL_HIGH;
                    endcase
                    n_cmd = r_cmd + 2'd1;
                    if (r_cmd == 2'd2) begin
                        n_state = ST_FRD;
                    end
                end
            end
            ST_FRD: begin
                n_addr = (AW + 1)'(32'(r_cur.page_sel) * SCREEN_WIDTH + 32'(col_end));
                mem_raddr = n_addr[AW-1:0];
                n_state   = ST_FOUT;
            end
            ST_FOUT: begin
                if (out_free) begin
                    n_ovalid         = 1'b1;
                    n_out.out_byte   = r_rdata;
                    n_out.is_command = 1'b0;
                    n_cnt            = r_cnt + 6'd1;
                    if ((32'(r_cnt) + 1 >= SEGMENT_BYTES)
                            || (32'(col_end) + 1 >= SCREEN_WIDTH)) begin
                        n_out.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_out.last = 1'b0;
                        n_state    = ST_FRD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_ovalid <= n_ovalid;
        end
        r_pass <= n_pass;
        r_col  <= n_col;
        r_cnt  <= n_cnt;
        r_cmd  <= n_cmd;
        r_out  <= n_out;
        if (o_pop) begin
            r_cur <= i_q_item;
        end
    end

    // Frame store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_valid    = r_ovalid;
    assign o_item     = r_out;
endmodule

// ----- tb/pftr_checker.sv -----
module pftr_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  pftr_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  pftr_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import pftr_pkg::*;

    localparam int WIDTH     = 128;
    localparam int PAGES     = 8;
    localparam int SEG_BYTES = 16;
    localparam int ROWS      = PAGES * 8;

    // code in the top byte, five font columns below, leftmost first
    localparam logic [47:0] FONT [68] = '{
        {"0", 40'h3E5149453E}, {"1", 40'h00427F4000}, {"2", 40'h4261514946},
        {"3", 40'h2141454B31}, {"4", 40'h1814127F10}, {"5", 40'h2745454539},
        {"6", 40'h3C4A494930}, {"7", 40'h0171090503}, {"8", 40'h3649494936},
        {"9", 40'h064949291E}, {"A", 40'h7E1111117E}, {"B", 40'h7F49494936},
        {"C", 40'h3E41414122}, {"D", 40'h7F4141221C}, {"E", 40'h7F49494941},
        {"F", 40'h7F09090901}, {"G", 40'h3E4149497A}, {"H", 40'h7F0808087F},
        {"I", 40'h00417F4100}, {"J", 40'h2040413F01}, {"K", 40'h7F08142241},
        {"L", 40'h7F40404040}, {"M", 40'h7F020C027F}, {"N", 40'h7F0408107F},
        {"O", 40'h3E4141413E}, {"P", 40'h7F09090906}, {"Q", 40'h3E4151215E},
        {"R", 40'h7F09192946}, {"S", 40'h4649494931}, {"T", 40'h01017F0101},
        {"U", 40'h3F4040403F}, {"V", 40'h1F2040201F}, {"W", 40'h3F4038403F},
        {"X", 40'h6314081463}, {"Y", 40'h0708700807}, {"Z", 40'h6151494543},
        {"a", 40'h2054545478}, {"b", 40'h7F48444438}, {"c", 40'h3844444420},
        {"d", 40'h384444487F}, {"e", 40'h3854545418}, {"f", 40'h087E090102},
        {"g", 40'h0C5252523E}, {"h", 40'h7F08040478}, {"i", 40'h00447D4000},
        {"j", 40'h2040443D00}, {"k", 40'h7F10284400}, {"l", 40'h00417F4000},
        {"m", 40'h7C04180478}, {"n", 40'h7C08040478}, {"o", 40'h3844444438},
        {"p", 40'h7C14141408}, {"q", 40'h081414187C}, {"r", 40'h7C08040408},
        {"s", 40'h4854545420}, {"t", 40'h043F444020}, {"u", 40'h3C4040207C},
        {"v", 40'h1C2040201C}, {"w", 40'h3C4030403C}, {"x", 40'h4428102844},
        {"y", 40'h0C5050503C}, {"z", 40'h4464544C44}, {" ", 40'h0000000000},
        {":", 40'h0036360000}, {".", 40'h0060600000}, {"-", 40'h0808080808},
        {"%", 40'h6313086463}, {"/", 40'h2010080402}
    };

    logic [7:0] frame [WIDTH*PAGES];
    t_out_item  panel_bytes[$];
    int         mismatches;

    function automatic logic [39:0] font_bits(input logic [7:0] code);
        foreach (FONT[g])
            if (FONT[g][47:40] == code) return FONT[g][39:0];
        return 40'h0;
    endfunction

    // clip, then update one bit of the store
    task automatic plot(input int x, input int y, input logic on);
        int idx;
        if (x >= WIDTH || y >= ROWS) return;
        idx = (y / 8) * WIDTH + x;
        frame[idx][y % 8] = on;
    endtask

    task automatic apply_request(input t_in_item req);
        logic [39:0] cols;
        logic [7:0]  bits;
        int          base;
        t_out_item   ob;
        case (req.mode)
            MODE_CLEAR: begin
                foreach (frame[i]) frame[i] = 8'h00;
            end
            MODE_PIXEL: plot(req.pos_x, req.pos_y, req.pixel_on);
            MODE_CHAR: begin
                if (req.pos_x < WIDTH && req.pos_y < ROWS) begin
                    cols = font_bits(req.char_code);
                    for (int c = 0; c <= 5; c++) begin
                        bits = (c < 5) ? cols[39-8*c -: 8] : 8'h00;
                        for (int r = 0; r < 7; r++)
                            plot(req.pos_x + c, req.pos_y + r, bits[r]);
                    end
                end
            end
            default: begin
                base = req.segment_sel * SEG_BYTES;
                if (req.page_sel < PAGES && base < WIDTH) begin
                    if (req.segment_sel == 3'd0) begin
                        panel_bytes.push_back('{CMD_PAGE_BASE | req.page_sel, 1'b1, 1'b0});
                        panel_bytes.push_back('{CMD_COL_LOW, 1'b1, 1'b0});
                        panel_bytes.push_back('{CMD_COL_HIGH, 1'b1, 1'b0});
                    end
                    for (int i = 0; i < SEG_BYTES && base + i < WIDTH; i++)
                        panel_bytes.push_back('{frame[req.page_sel*WIDTH + base + i],
                                                1'b0, 1'b0});
                    ob = panel_bytes.pop_back();
                    ob.last = 1'b1;
                    panel_bytes.push_back(ob);
                end
            end
        endcase
    endtask

    initial begin
        foreach (frame[i]) frame[i] = 8'h00;
        mismatches = 0;
    end

    // predict on each accepted request, compare each accepted panel byte
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) apply_request(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (panel_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected byte %h cmd %b last %b", i_out_item.out_byte,
                                 i_out_item.is_command, i_out_item.last);
                end else begin
                    want = panel_bytes.pop_front();
                    if (want != i_out_item) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("byte mismatch: want %h/%b/%b got %h/%b/%b",
                                     want.out_byte, want.is_command, want.last,
                                     i_out_item.out_byte, i_out_item.is_command,
                                     i_out_item.last);
                    end
                end
            end
        end
    end

    assign o_fail_count = mismatches;
    assign o_pending    = panel_bytes.size();
endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import pftr_pkg::*;

    localparam int LIMIT = 800000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_in_item  i_item  = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;
    int        fail_count;
    int        pending;
    int        cycles = 0;
    int        stall_style = 0;

    localparam string FONT_CODES = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz :.-%/";

    page_framebuffer_text_renderer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    pftr_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_item(i_item),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_item(o_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    // abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // panel side backpressure: free-running, light and heavy stretches
    always @(negedge i_clk) begin
        if (cycles % 300 == 0) stall_style <= $urandom_range(0, 2);
        case (stall_style)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // hold the request until it is taken
    task automatic send(input t_in_item req);
        i_valid <= 1'b1;
        i_item  <= req;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic pause(input int n);
        i_valid <= 1'b0;
        i_item  <= t_in_item'({$urandom, $urandom});
        repeat (n) @(negedge i_clk);
    endtask

    function automatic t_in_item make(input logic [1:0] m, input logic [7:0] x,
                                      input logic [7:0] y, input logic on,
                                      input logic [7:0] code, input logic [2:0] pg,
                                      input logic [2:0] seg);
        t_in_item r;
        r = '{m, x, y, on, code, pg, seg};
        return r;
    endfunction

    function automatic t_in_item random_request();
        t_in_item r;
        int       pick;
        r = t_in_item'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 2)       r.mode = MODE_CLEAR;
        else if (pick < 38) r.mode = MODE_PIXEL;
        else if (pick < 70) r.mode = MODE_CHAR;
        else                r.mode = MODE_FLUSH;
        // mostly on screen, some anywhere
        if ($urandom_range(0, 9) != 0) begin
            r.pos_x = 8'($urandom_range(0, 127));
            r.pos_y = 8'($urandom_range(0, 63));
        end
        if ($urandom_range(0, 7) != 0)
            r.char_code = FONT_CODES[$urandom_range(0, FONT_CODES.len() - 1)];
        return r;
    endfunction

    initial begin
        t_in_item req;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners, clipping, blank and unknown glyphs, every flush shape
        send(make(MODE_PIXEL, 8'd0, 8'd0, 1'b1, 8'h00, 3'd0, 3'd0));
        send(make(MODE_PIXEL, 8'd127, 8'd63, 1'b1, 8'hFF, 3'd7, 3'd7));
        send(make(MODE_PIXEL, 8'd128, 8'd0, 1'b1, 8'h00, 3'd0, 3'd0));
        send(make(MODE_PIXEL, 8'd0, 8'd64, 1'b1, 8'h00, 3'd0, 3'd0));
        send(make(MODE_PIXEL, 8'd255, 8'd255, 1'b1, 8'h00, 3'd0, 3'd0));
        send(make(MODE_PIXEL, 8'd5, 8'd3, 1'b1, 8'h00, 3'd0, 3'd0));
        send(make(MODE_PIXEL, 8'd5, 8'd3, 1'b0, 8'h00, 3'd0, 3'd0));
        send(make(MODE_CHAR, 8'd0, 8'd0, 1'b0, "A", 3'd0, 3'd0));
        send(make(MODE_CHAR, 8'd6, 8'd0, 1'b0, "0", 3'd0, 3'd0));
        send(make(MODE_CHAR, 8'd12, 8'd4, 1'b0, 8'h80, 3'd0, 3'd0));
        send(make(MODE_CHAR, 8'd124, 8'd60, 1'b0, "W", 3'd0, 3'd0));
        send(make(MODE_CHAR, 8'd250, 8'd0, 1'b0, "B", 3'd0, 3'd0));
        send(make(MODE_CHAR, 8'd0, 8'd200, 1'b0, "B", 3'd0, 3'd0));
        send(make(MODE_CHAR, 8'd2, 8'd1, 1'b0, 8'hFF, 3'd0, 3'd0));
        send(make(MODE_FLUSH, 8'd0, 8'd0, 1'b0, 8'h00, 3'd0, 3'd0));
        send(make(MODE_FLUSH, 8'd0, 8'd0, 1'b0, 8'h00, 3'd0, 3'd1));
        send(make(MODE_FLUSH, 8'd0, 8'd0, 1'b0, 8'h00, 3'd7, 3'd7));
        send(make(MODE_FLUSH, 8'd0, 8'd0, 1'b0, 8'h00, 3'd7, 3'd0));
        send(make(MODE_CLEAR, 8'hFF, 8'hFF, 1'b1, 8'hFF, 3'd7, 3'd7));
        send(make(MODE_FLUSH, 8'd0, 8'd0, 1'b0, 8'h00, 3'd0, 3'd0));

        // random bursts with gaps; drain once midway
        for (int n = 0; n < 420; ) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++, n++) begin
                req = random_request();
                send(req);
                if (n == 200) begin
                    i_valid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                    repeat (40) @(negedge i_clk);
                end
            end
            if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 15));
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
